/* design/calibration_table_store_assert.svh */
// Assertion macros used by the checker module of the calibration table store.
`ifndef CALIBRATION_TABLE_STORE_ASSERT_SVH
`define CALIBRATION_TABLE_STORE_ASSERT_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define CTS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define CTS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* design/cts_pkg.sv */
// Package with types and constants of the calibration table store.
package cts_pkg;

  localparam int TABLE_ROWS_DEF = 8;
  localparam int TABLE_COLS_DEF = 8;

  localparam int FUEL_OOR = 100;
  localparam int IGN_OOR = 10;

  localparam int DEF_FUEL_BASE = 80;
  localparam int DEF_FUEL_COL_STEP = 5;
  localparam int DEF_IGN_BASE = 5;

  typedef enum logic [3:0] {
    MODE_RD_FUEL    = 4'd0,
    MODE_WR_FUEL    = 4'd1,
    MODE_RD_IGN     = 4'd2,
    MODE_WR_IGN     = 4'd3,
    MODE_DEFAULTS   = 4'd4,
    MODE_COMMIT     = 4'd5,
    MODE_IMG_FUEL   = 4'd6,
    MODE_IMG_IGN    = 4'd7,
    MODE_IMG_SUM    = 4'd8,
    MODE_INIT_CHECK = 4'd9,
    MODE_VALIDATE   = 4'd10
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  row_index;
    logic [7:0]  col_index;
    logic [7:0]  entry_value;
    logic [15:0] image_sum;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        ok;
    logic [15:0] checksum_now;
  } out_t;

endpackage

/* design/cts_default_gen.sv */
// Default calibration pattern for one table position, saturated to a byte.
module cts_default_gen #(
  parameter int RowW = 3,
  parameter int ColW = 3
) (
  input  logic [RowW-1:0] row_i,
  input  logic [ColW-1:0] col_i,
  output logic [7:0]      fuel_o,
  output logic [7:0]      ign_o
);

  logic [9:0] fuel_raw;
  logic [9:0] ign_raw;

  always_comb begin
    fuel_raw = 10'(cts_pkg::DEF_FUEL_BASE) + (10'(row_i) << 1)
             + 10'(col_i) * 10'(cts_pkg::DEF_FUEL_COL_STEP);
    ign_raw  = 10'(cts_pkg::DEF_IGN_BASE) + 10'(row_i)
             + ((col_i == '0) ? 10'd0 : ((10'(col_i) << 1) - 10'd1));
    fuel_o   = (fuel_raw > 10'd255) ? 8'hFF : fuel_raw[7:0];
    ign_o    = (ign_raw > 10'd255) ? 8'hFF : ign_raw[7:0];
  end

endmodule

/* design/calibration_table_store.sv */
// Top level of the calibration table store: two table memories and the command sequencer.
//
//   Channel | Direction | Handshake               | Beat contents
//   in      | input     | in_valid_i / in_stall_o | cts_pkg::in_t  (mode, indices, data)
//   out     | output    | out_valid_o/out_stall_i | cts_pkg::out_t (value, ok, checksum)
//
// Commands are taken one at a time. An in-range read passes through the read state; any
// other short command goes straight to the done state. A write with recompute, a commit or
// a validate walks the checksum, reading one entry of each table memory per cycle.
// Loading defaults fills both tables, then walks the checksum; an init check walks it and,
// on a mismatch, loads defaults. After reset a clearing pass zeroes both tables first.
// A finished result waits in the output register; the next command is taken meanwhile.
module calibration_table_store #(
  parameter int TableRows = cts_pkg::TABLE_ROWS_DEF,
  parameter int TableCols = cts_pkg::TABLE_COLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cts_pkg::out_t out_data_o
);

  localparam int Cells = TableRows * TableCols;
  localparam int AddrW = $clog2(Cells);
  localparam int CntW  = $clog2(Cells + 1);
  localparam int RowW  = $clog2(TableRows);
  localparam int ColW  = $clog2(TableCols);

  cts_pkg::state_e state_q, state_d;
  cts_pkg::mode_e  cmd_q, cmd_d;
  cts_pkg::mode_e  in_mode;
  logic            fallback_q, fallback_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [15:0]     acc_q, acc_d;
  logic            acc_en_q, acc_en_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      res_rd_q, res_rd_d;
  logic            res_ok_q, res_ok_d;
  logic            out_vld_q;
  cts_pkg::out_t   out_q;
  logic            out_load;

  logic [7:0]       fuel_mem [Cells];
  logic [7:0]       ign_mem [Cells];
  logic [7:0]       fuel_rd_q, ign_rd_q;
  logic             fuel_we, ign_we;
  logic [AddrW-1:0] waddr, rd_addr;
  logic [7:0]       fuel_wdata, ign_wdata;
  logic [7:0]       def_fuel, def_ign;

  logic             accept;
  logic             in_range;
  logic [AddrW-1:0] in_addr;
  logic [15:0]      sum_next;
  logic             compare_only;
  logic             sum_match;

  cts_default_gen #(
    .RowW (RowW),
    .ColW (ColW)
  ) u_default_gen (
    .row_i  (row_q),
    .col_i  (col_q),
    .fuel_o (def_fuel),
    .ign_o  (def_ign)
  );

  assign in_stall_o  = (state_q != cts_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_mode     = cts_pkg::mode_e'(in_data_i.mode);
  assign in_range    = (in_data_i.row_index < 8'(TableRows))
                    && (in_data_i.col_index < 8'(TableCols));
  assign in_addr     = AddrW'(in_data_i.row_index[RowW-1:0]) * AddrW'(TableCols)
                     + AddrW'(in_data_i.col_index[ColW-1:0]);
  assign sum_next    = acc_q + (acc_en_q ? (16'(fuel_rd_q) + 16'(ign_rd_q)) : 16'd0);
  assign sum_match   = (sum_next == sum_q);
  assign compare_only = (cmd_q == cts_pkg::MODE_VALIDATE)
                     || ((cmd_q == cts_pkg::MODE_INIT_CHECK) && !fallback_q);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    fallback_d = fallback_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    acc_d      = acc_q;
    acc_en_d   = 1'b0;
    sum_d      = sum_q;
    res_rd_d   = res_rd_q;
    res_ok_d   = res_ok_q;
    fuel_we    = 1'b0;
    ign_we     = 1'b0;
    waddr      = cnt_q[AddrW-1:0];
    rd_addr    = cnt_q[AddrW-1:0];
    fuel_wdata = def_fuel;
    ign_wdata  = def_ign;
    out_load   = 1'b0;

    unique case (state_q)
      cts_pkg::ST_CLEAR: begin
        fuel_we    = 1'b1;
        ign_we     = 1'b1;
        fuel_wdata = 8'd0;
        ign_wdata  = 8'd0;
        if (cnt_q == CntW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = cts_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cts_pkg::ST_IDLE: begin
        rd_addr    = in_addr;
        waddr      = in_addr;
        fuel_wdata = in_data_i.entry_value;
        ign_wdata  = in_data_i.entry_value;
        if (accept) begin
          cmd_d      = in_mode;
          fallback_d = 1'b0;
          res_rd_d   = 8'd0;
          res_ok_d   = 1'b0;
          cnt_d      = '0;
          row_d      = '0;
          col_d      = '0;
          acc_d      = 16'd0;
          state_d    = cts_pkg::ST_DONE;
          unique case (in_mode) inside
            cts_pkg::MODE_RD_FUEL, cts_pkg::MODE_RD_IGN: begin
              if (in_range) begin
                state_d = cts_pkg::ST_READ;
              end else begin
                res_rd_d = (in_mode == cts_pkg::MODE_RD_FUEL) ?
                           8'(cts_pkg::FUEL_OOR) : 8'(cts_pkg::IGN_OOR);
              end
            end
            cts_pkg::MODE_WR_FUEL, cts_pkg::MODE_IMG_FUEL: begin
              fuel_we  = in_range;
              res_ok_d = in_range;
              if (in_range && (in_mode == cts_pkg::MODE_WR_FUEL)) begin
                state_d = cts_pkg::ST_SUM;
              end
            end
            cts_pkg::MODE_WR_IGN, cts_pkg::MODE_IMG_IGN: begin
              ign_we   = in_range;
              res_ok_d = in_range;
              if (in_range && (in_mode == cts_pkg::MODE_WR_IGN)) begin
                state_d = cts_pkg::ST_SUM;
              end
            end
            cts_pkg::MODE_DEFAULTS: begin
              state_d = cts_pkg::ST_FILL;
            end
            cts_pkg::MODE_COMMIT, cts_pkg::MODE_INIT_CHECK, cts_pkg::MODE_VALIDATE: begin
              state_d = cts_pkg::ST_SUM;
            end
            cts_pkg::MODE_IMG_SUM: begin
              sum_d    = in_data_i.image_sum;
              res_ok_d = 1'b1;
            end
            default: begin
              state_d = cts_pkg::ST_DONE;
            end
          endcase
        end
      end
      cts_pkg::ST_READ: begin
        res_rd_d = (cmd_q == cts_pkg::MODE_RD_FUEL) ? fuel_rd_q : ign_rd_q;
        res_ok_d = 1'b1;
        state_d  = cts_pkg::ST_DONE;
      end
      cts_pkg::ST_FILL: begin
        fuel_we = 1'b1;
        ign_we  = 1'b1;
        if (col_q == ColW'(TableCols - 1)) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        if (cnt_q == CntW'(Cells - 1)) begin
          cnt_d   = '0;
          acc_d   = 16'd0;
          state_d = cts_pkg::ST_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cts_pkg::ST_SUM: begin
        if (cnt_q != CntW'(Cells)) begin
          cnt_d    = cnt_q + 1'b1;
          acc_d    = sum_next;
          acc_en_d = 1'b1;
        end else begin
          state_d = cts_pkg::ST_DONE;
          if (compare_only) begin
            res_ok_d = sum_match;
            if ((cmd_q == cts_pkg::MODE_INIT_CHECK) && !sum_match) begin
              fallback_d = 1'b1;
              cnt_d      = '0;
              row_d      = '0;
              col_d      = '0;
              state_d    = cts_pkg::ST_FILL;
            end
          end else begin
            sum_d = sum_next;
            if (cmd_q != cts_pkg::MODE_INIT_CHECK) begin
              res_ok_d = 1'b1;
            end
          end
        end
      end
      cts_pkg::ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = cts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cts_pkg::ST_CLEAR;
      cmd_q      <= cts_pkg::MODE_RD_FUEL;
      fallback_q <= 1'b0;
      cnt_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      acc_q      <= 16'd0;
      acc_en_q   <= 1'b0;
      sum_q      <= 16'd0;
      res_rd_q   <= 8'd0;
      res_ok_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      fallback_q <= fallback_d;
      cnt_q      <= cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      acc_q      <= acc_d;
      acc_en_q   <= acc_en_d;
      sum_q      <= sum_d;
      res_rd_q   <= res_rd_d;
      res_ok_q   <= res_ok_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.read_value   <= res_rd_q;
      out_q.ok           <= res_ok_q;
      out_q.checksum_now <= sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fuel_we) begin
      fuel_mem[waddr] <= fuel_wdata;
    end
    fuel_rd_q <= fuel_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ign_we) begin
      ign_mem[waddr] <= ign_wdata;
    end
    ign_rd_q <= ign_mem[rd_addr];
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* design/cts_checker.sv */
// Port-level assertion checker for the calibration table store, bound to the top level.
`include "calibration_table_store_assert.svh"

module cts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cts_pkg::out_t out_data_o
);

  logic fail_value_legal;

  assign fail_value_legal = (out_data_o.read_value == 8'd0)
                         || (out_data_o.read_value == 8'(cts_pkg::FUEL_OOR))
                         || (out_data_o.read_value == 8'(cts_pkg::IGN_OOR));

  `CTS_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `CTS_ASSERT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_data_o))
  `CTS_ASSERT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `CTS_ASSERT(a_fail_value, clk_i, rst_ni, out_valid_o && !out_data_o.ok |-> fail_value_legal)
  `CTS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind calibration_table_store cts_checker u_cts_checker (.*);

/* bench/calibration_table_store_check.sv */
// Checker for the calibration table store: predicts each result beat and compares it.
module calibration_table_store_check
  import cts_pkg::*;
#(
  parameter int Rows = TABLE_ROWS_DEF,
  parameter int Cols = TABLE_COLS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   mismatches_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cells = Rows * Cols;
  localparam int PrintCap = 30;

  logic [7:0]  fuel_map [Cells];
  logic [7:0]  ign_map [Cells];
  logic [15:0] stored_chk;
  out_t        expected_results [$];

  function automatic logic [15:0] table_sum();
    logic [15:0] s;
    s = '0;
    for (int k = 0; k < Cells; k++) s += 16'(fuel_map[k]);
    for (int k = 0; k < Cells; k++) s += 16'(ign_map[k]);
    return s;
  endfunction

  function automatic logic [7:0] clip8(int unsigned v);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic void fill_defaults();
    for (int unsigned r = 0; r < Rows; r++) begin
      for (int unsigned c = 0; c < Cols; c++) begin
        fuel_map[r * Cols + c] = clip8(DEF_FUEL_BASE + 2 * r + DEF_FUEL_COL_STEP * c);
        ign_map[r * Cols + c] = clip8(DEF_IGN_BASE + r + ((c == 0) ? 0 : 2 * c - 1));
      end
    end
    stored_chk = table_sum();
  endfunction

  function automatic out_t predict_result(in_t cmd);
    out_t        res;
    logic        in_range;
    int unsigned k;
    res = '0;
    in_range = (cmd.row_index < Rows) && (cmd.col_index < Cols);
    k = in_range ? cmd.row_index * Cols + cmd.col_index : 0;
    case (cmd.mode)
      MODE_RD_FUEL: begin
        res.read_value = in_range ? fuel_map[k] : 8'(FUEL_OOR);
        res.ok = in_range;
      end
      MODE_RD_IGN: begin
        res.read_value = in_range ? ign_map[k] : 8'(IGN_OOR);
        res.ok = in_range;
      end
      MODE_WR_FUEL, MODE_IMG_FUEL: begin
        if (in_range) begin
          fuel_map[k] = cmd.entry_value;
          if (cmd.mode == MODE_WR_FUEL) stored_chk = table_sum();
          res.ok = 1'b1;
        end
      end
      MODE_WR_IGN, MODE_IMG_IGN: begin
        if (in_range) begin
          ign_map[k] = cmd.entry_value;
          if (cmd.mode == MODE_WR_IGN) stored_chk = table_sum();
          res.ok = 1'b1;
        end
      end
      MODE_DEFAULTS: begin
        fill_defaults();
        res.ok = 1'b1;
      end
      MODE_COMMIT: begin
        stored_chk = table_sum();
        res.ok = 1'b1;
      end
      MODE_IMG_SUM: begin
        stored_chk = cmd.image_sum;
        res.ok = 1'b1;
      end
      MODE_INIT_CHECK: begin
        res.ok = (table_sum() == stored_chk);
        if (!res.ok) fill_defaults();
      end
      MODE_VALIDATE: begin
        res.ok = (table_sum() == stored_chk);
      end
      default: begin
      end
    endcase
    res.checksum_now = stored_chk;
    return res;
  endfunction

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    if (mismatches_o < PrintCap) begin
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int k = 0; k < Cells; k++) begin
        fuel_map[k] = '0;
        ign_map[k] = '0;
      end
      stored_chk = '0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result beat", out_data_i.checksum_now, 16'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.read_value !== want.read_value) begin
            report("read_value", 16'(out_data_i.read_value), 16'(want.read_value));
          end
          if (out_data_i.ok !== want.ok) begin
            report("ok", 16'(out_data_i.ok), 16'(want.ok));
          end
          if (out_data_i.checksum_now !== want.checksum_now) begin
            report("checksum_now", out_data_i.checksum_now, want.checksum_now);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_result(in_data_i));
      pending_o = expected_results.size();
    end
  end

endmodule

/* bench/calibration_table_store_test.sv */
// Top of the calibration table store testbench: clock, reset, command stimulus and verdict.
module calibration_table_store_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  localparam int Rows = TABLE_ROWS_DEF;
  localparam int Cols = TABLE_COLS_DEF;
  localparam int RandomItems = 800;
  localparam int IdleLimit = 2000;
  localparam int TailCycles = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_t out_data;

  int mismatches;
  int pending;
  int beats = 0;
  int boots = 0;
  int drains = 0;
  int idle_run = 0;
  bit calm = 1'b0;

  always #2 clk = ~clk;

  calibration_table_store uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  calibration_table_store_check #(
    .Rows(Rows),
    .Cols(Cols)
  ) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  function automatic in_t make_cmd(input logic [3:0] m, input int r = 0, input int c = 0,
                                   input int v = 0, input int s = 0);
    in_t b;
    b.mode = m;
    b.row_index = 8'(r);
    b.col_index = 8'(c);
    b.entry_value = 8'(v);
    b.image_sum = 16'(s);
    return b;
  endfunction

  function automatic in_t random_cmd();
    in_t b;
    int  w;
    if ($urandom_range(0, 4) != 0) begin
      b.row_index = 8'($urandom_range(0, Rows - 1));
      b.col_index = 8'($urandom_range(0, Cols - 1));
    end else begin
      b.row_index = 8'($urandom_range(0, 255));
      b.col_index = 8'($urandom_range(0, 255));
    end
    b.entry_value = 8'($urandom);
    b.image_sum = 16'($urandom);
    w = $urandom_range(0, 99);
    if (w < 20) b.mode = MODE_RD_FUEL;
    else if (w < 35) b.mode = MODE_RD_IGN;
    else if (w < 50) b.mode = MODE_WR_FUEL;
    else if (w < 62) b.mode = MODE_WR_IGN;
    else if (w < 68) b.mode = MODE_IMG_FUEL;
    else if (w < 74) b.mode = MODE_IMG_IGN;
    else if (w < 78) b.mode = MODE_IMG_SUM;
    else if (w < 83) b.mode = MODE_COMMIT;
    else if (w < 87) b.mode = MODE_VALIDATE;
    else if (w < 91) b.mode = MODE_INIT_CHECK;
    else if (w < 95) b.mode = MODE_DEFAULTS;
    else b.mode = 4'($urandom_range(MODE_VALIDATE + 1, 15));
    return b;
  endfunction

  task automatic push_beat(input in_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    beats++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    drains++;
  endtask

  // A start-up image: every entry of both tables, the checksum, the check, then a validate.
  task automatic image_boot(input bit corrupt);
    logic [15:0] total;
    logic [7:0]  v;
    logic [3:0]  m;
    total = '0;
    for (int t = 0; t < 2; t++) begin
      m = (t == 0) ? MODE_IMG_FUEL : MODE_IMG_IGN;
      for (int r = 0; r < Rows; r++) begin
        for (int c = 0; c < Cols; c++) begin
          if ($urandom_range(0, 15) == 0) begin
            push_beat(make_cmd(m, $urandom_range(Rows, 255), $urandom_range(0, 255), $urandom));
          end
          v = 8'($urandom);
          push_beat(make_cmd(m, r, c, v));
          total += 16'(v);
        end
      end
    end
    if (corrupt) total ^= 16'(1 << $urandom_range(0, 15));
    push_beat(make_cmd(MODE_IMG_SUM, 0, 0, 0, total));
    push_beat(make_cmd(MODE_INIT_CHECK));
    push_beat(make_cmd(MODE_VALIDATE));
    boots++;
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_beat(make_cmd(MODE_VALIDATE));
    push_beat(make_cmd(MODE_INIT_CHECK));
    push_beat(make_cmd(MODE_RD_FUEL, 0, 0));
    push_beat(make_cmd(MODE_RD_IGN, Rows - 1, Cols - 1));
    push_beat(make_cmd(MODE_WR_FUEL, 0, 0, 255));
    push_beat(make_cmd(MODE_WR_FUEL, Rows - 1, Cols - 1, 8'h80));
    push_beat(make_cmd(MODE_WR_FUEL, Rows, 0, 8'h11));
    push_beat(make_cmd(MODE_WR_FUEL, 0, 255, 8'h22));
    push_beat(make_cmd(MODE_WR_IGN, Rows - 1, 0, 255));
    push_beat(make_cmd(MODE_WR_IGN, 255, 255, 0));
    push_beat(make_cmd(MODE_RD_FUEL, 255, 0));
    push_beat(make_cmd(MODE_RD_IGN, 0, Cols));
    push_beat(make_cmd(MODE_IMG_FUEL, 3, 4, 8'hAA));
    push_beat(make_cmd(MODE_IMG_IGN, Rows - 1, Cols - 1, 8'h55));
    push_beat(make_cmd(MODE_IMG_IGN, Rows, Cols, 8'h77));
    push_beat(make_cmd(MODE_VALIDATE));
    push_beat(make_cmd(MODE_COMMIT));
    push_beat(make_cmd(MODE_VALIDATE));
    push_beat(make_cmd(MODE_IMG_SUM, 0, 0, 0, 16'hFFFF));
    push_beat(make_cmd(MODE_INIT_CHECK));
    push_beat(make_cmd(MODE_VALIDATE));
    push_beat(make_cmd(MODE_DEFAULTS));
    push_beat(make_cmd(MODE_RD_FUEL, Rows - 1, Cols - 1));
    push_beat(make_cmd(MODE_RD_IGN, 0, Cols - 1));
    push_beat(make_cmd(4'(MODE_VALIDATE + 1)));
    push_beat(make_cmd(4'hF, 0, 0, 255, 16'hFFFF));
    push_beat(make_cmd(MODE_IMG_SUM, 0, 0, 0, 16'h0000));
    drain();

    target = beats + RandomItems;
    image_boot(1'b0);
    while (beats < target) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if (boots < 3 && $urandom_range(0, 39) == 0) begin
        image_boot(boots == 1);
      end else if ($urandom_range(0, 59) == 0) begin
        drain();
      end else begin
        push_beat(random_cmd());
      end
    end
    drain();
    repeat (TailCycles) @(negedge clk);

    $display("Sent %0d command beats, with %0d full image loads and %0d pauses until idle.",
             beats, boots, drains);
    $display("Random beats mixed reads, writes, image writes and checksum operations.");
    if (mismatches == 0) begin
      $display("calibration_table_store test passed");
    end else begin
      $display("calibration_table_store test failed");
    end
    $finish;
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = calm ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= IdleLimit) begin
      $display("calibration_table_store test failed");
      $finish;
    end
  end

endmodule
